// ----- design/tofk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_pkg
// Shared types and constants for the time-of-flight kinematics pipeline.
// ---------------------------------------------------------------------------
package tofk_pkg;

  // speed of light in 0.1 mm per ps, Q24
  localparam logic [25:0] LIGHT_Q24 = 26'd50296828;
  localparam logic [19:0] MASS_RESET = 20'd105658;

  localparam int SQ_W = 48;  // radicand width of the root extractor
  localparam int RT_W = 24;  // root width
  localparam int BETA_W = 16;
  localparam int DIST_W = 58;
  localparam int RECIP_W = 48;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_TOF  = 2'd1;
  localparam logic [1:0] STATUS_FAST = 2'd2;

  typedef struct packed {
    logic signed [19:0] first_x;
    logic signed [19:0] first_y;
    logic signed [19:0] first_z;
    logic signed [31:0] first_time;
    logic [2:0]         first_station;
    logic signed [19:0] second_x;
    logic signed [19:0] second_y;
    logic signed [19:0] second_z;
    logic signed [31:0] second_time;
    logic [2:0]         second_station;
  } tofk_in_t;

  typedef struct packed {
    logic signed [32:0] flight_time;
    logic [20:0]        path_length;
    logic [16:0]        beta_value;
    logic [23:0]        gamma_value;
    logic [31:0]        momentum;
    logic               stations_differ;
    logic [1:0]         status;
  } tofk_out_t;

  // everything that travels alongside the arithmetic units
  typedef struct packed {
    logic [32:0]        flight_time;
    logic [20:0]        path_length;
    logic [BETA_W-1:0]  beta;
    logic [DIST_W-1:0]  light_path;
    logic [1:0]         status;
    logic               stations_differ;
  } tofk_side_t;

endpackage
`default_nettype wire

// ----- design/tofk_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_front
// Orders the hits, forms flight time, squared distance and light path.
// ---------------------------------------------------------------------------
module tofk_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire tofk_pkg::tofk_in_t       in_data,
  output logic                          out_valid,
  output logic [tofk_pkg::SQ_W-1:0]     out_rad,
  output tofk_pkg::tofk_side_t          out_side
);

  function automatic logic [19:0] abs_diff(input logic [19:0] a, input logic [19:0] b);
    logic [20:0] d;
    logic [20:0] n;
    d = {a[19], a} - {b[19], b};
    n = 21'd0 - d;
    return d[20] ? n[19:0] : d[19:0];
  endfunction

  // stage 1
  logic        v1_r;
  logic [32:0] tof_r, tof_nxt;
  logic [19:0] dx_r, dy_r, dz_r;
  logic        sd_r;
  logic [32:0] ta, tb;

  always_comb begin
    ta = {in_data.first_time[31], in_data.first_time};
    tb = {in_data.second_time[31], in_data.second_time};
    if (in_data.first_z < in_data.second_z) begin
      tof_nxt = tb - ta;
    end else begin
      tof_nxt = ta - tb;
    end
  end

  // stage 2
  logic        v2_r;
  logic [39:0] sx_r, sy_r, sz_r;
  logic [tofk_pkg::DIST_W-1:0] dist_r;
  logic [32:0] tof2_r;
  logic        sd2_r;

  // stage 3
  logic        v3_r;
  logic [41:0] sum_r;
  logic [tofk_pkg::DIST_W-1:0] dist3_r;
  logic [32:0] tof3_r;
  logic        sd3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tof_r   <= tof_nxt;
    dx_r    <= abs_diff(in_data.first_x, in_data.second_x);
    dy_r    <= abs_diff(in_data.first_y, in_data.second_y);
    dz_r    <= abs_diff(in_data.first_z, in_data.second_z);
    sd_r    <= (in_data.first_station != in_data.second_station);
    sx_r    <= 40'(dx_r) * 40'(dx_r);
    sy_r    <= 40'(dy_r) * 40'(dy_r);
    sz_r    <= 40'(dz_r) * 40'(dz_r);
    // only meaningful for a positive flight time, which fits in 32 bits
    dist_r  <= 58'(tof_r[31:0]) * 58'(tofk_pkg::LIGHT_Q24);
    tof2_r  <= tof_r;
    sd2_r   <= sd_r;
    sum_r   <= 42'(sx_r) + 42'(sy_r) + 42'(sz_r);
    dist3_r <= dist_r;
    tof3_r  <= tof2_r;
    sd3_r   <= sd2_r;
  end

  always_comb begin
    out_valid                = v3_r;
    out_rad                  = {4'd0, sum_r, 2'b00};
    out_side.flight_time     = tof3_r;
    out_side.path_length     = '0;
    out_side.beta            = '0;
    out_side.light_path      = dist3_r;
    out_side.status          = tofk_pkg::STATUS_OK;
    out_side.stations_differ = sd3_r;
  end

endmodule
`default_nettype wire

// ----- design/tofk_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_isqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module tofk_isqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [tofk_pkg::SQ_W-1:0] in_rad,
  input  wire tofk_pkg::tofk_side_t     in_side,
  output logic                          out_valid,
  output logic [tofk_pkg::RT_W-1:0]     out_root,
  output tofk_pkg::tofk_side_t          out_side
);

  localparam int N = tofk_pkg::RT_W;
  localparam int SW = tofk_pkg::SQ_W;

  logic                 vld_r  [N];
  logic [SW-1:0]        rad_r  [N];
  logic [N+1:0]         rem_r  [N];
  logic [N-1:0]         root_r [N];
  tofk_pkg::tofk_side_t side_r [N];

  logic [SW-1:0]        rad_nxt  [N];
  logic [N+1:0]         rem_nxt  [N];
  logic [N-1:0]         root_nxt [N];

  always_comb begin
    logic [SW-1:0] rad;
    logic [N+1:0]  rem;
    logic [N-1:0]  root;
    logic [N+1:0]  rsh;
    logic [N+1:0]  trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rad  = in_rad;
        rem  = '0;
        root = '0;
      end else begin
        rad  = rad_r[k-1];
        rem  = rem_r[k-1];
        root = root_r[k-1];
      end
      rsh   = {rem[N-1:0], rad[SW-1:SW-2]};
      trial = {root, 2'b01};
      rad_nxt[k] = {rad[SW-3:0], 2'b00};
      if (rsh >= trial) begin
        rem_nxt[k]  = rsh - trial;
        root_nxt[k] = {root[N-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rsh;
        root_nxt[k] = {root[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 1; k < N; k++) side_r[k] <= side_r[k-1];
    for (int k = 0; k < N; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule
`default_nettype wire

// ----- design/tofk_beta_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_beta_div
// Rounds the path length, classifies the pair and divides out beta.
// ---------------------------------------------------------------------------
module tofk_beta_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [tofk_pkg::RT_W-1:0] in_root,
  input  wire tofk_pkg::tofk_side_t     in_side,
  output logic                          out_valid,
  output tofk_pkg::tofk_side_t          out_side
);

  localparam int N = tofk_pkg::BETA_W;
  localparam int DW = tofk_pkg::DIST_W;

  // preparation stage
  logic [tofk_pkg::RT_W:0] rnd;
  logic [20:0]             len;
  logic [44:0]             l24;
  logic [1:0]              st_nxt;
  logic                    pv_r;
  tofk_pkg::tofk_side_t    ps_r, ps_nxt;

  always_comb begin
    rnd = {1'b0, in_root} + 25'd1;
    len = rnd[21:1];
    l24 = {len, 24'd0};
    if (in_side.flight_time[32] || (in_side.flight_time == 33'd0)) begin
      st_nxt = tofk_pkg::STATUS_TOF;
    end else if (DW'(l24) >= in_side.light_path) begin
      st_nxt = tofk_pkg::STATUS_FAST;
    end else begin
      st_nxt = tofk_pkg::STATUS_OK;
    end
    ps_nxt             = in_side;
    ps_nxt.path_length = len;
    ps_nxt.status      = st_nxt;
  end

  logic            vld_r [N];
  logic [DW:0]     rem_r [N];
  logic [N-1:0]    quo_r [N];
  tofk_pkg::tofk_side_t side_r [N];
  logic [DW:0]     rem_nxt [N];
  logic [N-1:0]    quo_nxt [N];

  always_comb begin
    logic [DW:0]  rem;
    logic [N-1:0] quo;
    logic [DW:0]  r2;
    logic [DW:0]  dv;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem = (DW+1)'({ps_r.path_length, 24'd0});
        quo = '0;
        dv  = {1'b0, ps_r.light_path};
      end else begin
        rem = rem_r[k-1];
        quo = quo_r[k-1];
        dv  = {1'b0, side_r[k-1].light_path};
      end
      r2 = {rem[DW-1:0], 1'b0};
      if (r2 >= dv) begin
        rem_nxt[k] = r2 - dv;
        quo_nxt[k] = {quo[N-2:0], 1'b1};
      end else begin
        rem_nxt[k] = r2;
        quo_nxt[k] = {quo[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else begin
      pv_r     <= in_valid;
      vld_r[0] <= pv_r;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    ps_r      <= ps_nxt;
    side_r[0] <= ps_r;
    for (int k = 1; k < N; k++) side_r[k] <= side_r[k-1];
    for (int k = 0; k < N; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  always_comb begin
    out_valid     = vld_r[N-1];
    out_side      = side_r[N-1];
    out_side.beta = quo_r[N-1];
  end

endmodule
`default_nettype wire

// ----- design/tofk_recip.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_recip
// Forms 2^64 / (2^32 - beta^2), one quotient bit per stage.
// ---------------------------------------------------------------------------
module tofk_recip (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire tofk_pkg::tofk_side_t     in_side,
  output logic                          out_valid,
  output logic [tofk_pkg::SQ_W-1:0]     out_quo,
  output tofk_pkg::tofk_side_t          out_side
);

  localparam int N = tofk_pkg::RECIP_W;

  logic                 bv_r;
  logic [31:0]          bsq_r;
  tofk_pkg::tofk_side_t bs_r;
  logic [32:0]          den;

  // denominator is at least 2^17 - 1, so the quotient fits in 48 bits
  assign den = 33'h1_0000_0000 - {1'b0, bsq_r};

  logic                 vld_r  [N];
  logic [33:0]          rem_r  [N];
  logic [32:0]          den_r  [N];
  logic [N-1:0]         quo_r  [N];
  tofk_pkg::tofk_side_t side_r [N];
  logic [33:0]          rem_nxt [N];
  logic [N-1:0]         quo_nxt [N];

  always_comb begin
    logic [33:0]  rem;
    logic [33:0]  dv;
    logic [N-1:0] quo;
    logic [33:0]  r2;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem = 34'h1_0000;
        dv  = {1'b0, den};
        quo = '0;
      end else begin
        rem = rem_r[k-1];
        dv  = {1'b0, den_r[k-1]};
        quo = quo_r[k-1];
      end
      r2 = {rem[32:0], 1'b0};
      if (r2 >= dv) begin
        rem_nxt[k] = r2 - dv;
        quo_nxt[k] = {quo[N-2:0], 1'b1};
      end else begin
        rem_nxt[k] = r2;
        quo_nxt[k] = {quo[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else begin
      bv_r     <= in_valid;
      vld_r[0] <= bv_r;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    bsq_r     <= 32'(in_side.beta) * 32'(in_side.beta);
    bs_r      <= in_side;
    den_r[0]  <= den;
    side_r[0] <= bs_r;
    for (int k = 1; k < N; k++) begin
      den_r[k]  <= den_r[k-1];
      side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

endmodule
`default_nettype wire

// ----- design/tofk_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_back
// Momentum from mass, beta and gamma, saturation and the result register.
// ---------------------------------------------------------------------------
module tofk_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [tofk_pkg::RT_W-1:0] in_gamma,
  input  wire tofk_pkg::tofk_side_t     in_side,
  input  wire logic [19:0]              mass,
  output logic                          out_valid,
  output tofk_pkg::tofk_out_t           out_result
);

  logic                 v1_r, v2_r, v3_r;
  logic [39:0]          bg_r;
  logic [23:0]          g1_r, g2_r;
  tofk_pkg::tofk_side_t s1_r, s2_r;
  logic [59:0]          mom_r;
  tofk_pkg::tofk_out_t  res_r, res_nxt;

  always_comb begin
    res_nxt.flight_time     = s2_r.flight_time;
    res_nxt.path_length     = s2_r.path_length;
    res_nxt.stations_differ = s2_r.stations_differ;
    res_nxt.status          = s2_r.status;
    if (s2_r.status == tofk_pkg::STATUS_OK) begin
      res_nxt.beta_value  = {1'b0, s2_r.beta};
      res_nxt.gamma_value = g2_r;
      res_nxt.momentum    = {4'd0, mom_r[59:32]};
    end else begin
      res_nxt.beta_value  = '1;
      res_nxt.gamma_value = '1;
      res_nxt.momentum    = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    bg_r  <= 40'(in_side.beta) * 40'(in_gamma);
    g1_r  <= in_gamma;
    s1_r  <= in_side;
    mom_r <= 60'(bg_r) * 60'(mass);
    g2_r  <= g1_r;
    s2_r  <= s1_r;
    res_r <= res_nxt;
  end

  assign out_valid  = v3_r;
  assign out_result = res_r;

endmodule
`default_nettype wire

// ----- design/time_of_flight_kinematics.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// time_of_flight_kinematics
// Flight time, path length, beta, gamma and momentum from a pair of hits.
// ---------------------------------------------------------------------------
// A new hit pair is taken on every clock cycle (busy stays low) and its word
// appears on the result ports for one cycle, with out_valid high; the
// receiver must take it then. The pipeline is built from the bit-per-stage
// units: two 24-stage square roots, a 16-stage beta divider and a 48-stage
// reciprocal, plus eight stages of geometry, rounding and multiplication.
// The particle mass register should only be written while no pair is in
// flight.
module time_of_flight_kinematics (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tofk_pkg::tofk_in_t  in_data,
  output logic                     out_valid,
  output tofk_pkg::tofk_out_t      out_result,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  logic [19:0] mass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= tofk_pkg::MASS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      mass_r <= cfg_pwdata[19:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {12'd0, mass_r};
  assign busy       = 1'b0;

  logic                          f_valid, r1_valid, b_valid, q_valid, r2_valid;
  logic [tofk_pkg::SQ_W-1:0]     f_rad, q_quo;
  logic [tofk_pkg::RT_W-1:0]     r1_root, r2_root;
  tofk_pkg::tofk_side_t          f_side, r1_side, b_side, q_side, r2_side;

  tofk_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_data(in_data),
    .out_valid(f_valid), .out_rad(f_rad), .out_side(f_side)
  );

  tofk_isqrt u_len_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_rad(f_rad), .in_side(f_side),
    .out_valid(r1_valid), .out_root(r1_root), .out_side(r1_side)
  );

  tofk_beta_div u_beta (
    .clk(clk), .rst_n(rst_n), .in_valid(r1_valid), .in_root(r1_root),
    .in_side(r1_side), .out_valid(b_valid), .out_side(b_side)
  );

  tofk_recip u_recip (
    .clk(clk), .rst_n(rst_n), .in_valid(b_valid), .in_side(b_side),
    .out_valid(q_valid), .out_quo(q_quo), .out_side(q_side)
  );

  tofk_isqrt u_gamma_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_rad(q_quo), .in_side(q_side),
    .out_valid(r2_valid), .out_root(r2_root), .out_side(r2_side)
  );

  tofk_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(r2_valid), .in_gamma(r2_root),
    .in_side(r2_side), .mass(mass_r), .out_valid(out_valid), .out_result(out_result)
  );

endmodule
`default_nettype wire

// ----- design/tofk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tofk_checker
// Port-level checks on the result word and the handshake.
// ---------------------------------------------------------------------------
module tofk_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire tofk_pkg::tofk_out_t out_result
);

  // the pipeline never stalls its input
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.status == tofk_pkg::STATUS_OK ||
                   out_result.status == tofk_pkg::STATUS_TOF ||
                   out_result.status == tofk_pkg::STATUS_FAST))
    else $error("bad status code");

  // failed pairs saturate all derived quantities
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status != tofk_pkg::STATUS_OK) |->
      (&out_result.beta_value && &out_result.gamma_value && &out_result.momentum))
    else $error("failed word not saturated");

  // a good word is slower than light
  a_beta_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status == tofk_pkg::STATUS_OK) |->
      !out_result.beta_value[16])
    else $error("beta at or above one");

endmodule

bind time_of_flight_kinematics tofk_checker u_tofk_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_result(out_result)
);
`default_nettype wire
